// File: rtl/wwhs_pkg.sv
// Shared types and constants for the weekly window heat scheduler.
// Used by the channel interfaces, every RTL module and the checker.
`default_nettype none

package wwhs_pkg;

	// Field widths fixed by the register map and the item formats.
	localparam int MIN_W  = 11;
	localparam int SLOT_W = 44;
	localparam int CNT_W  = 3;
	localparam int IDX_W  = 3;

	// Kinds of input item.
	typedef enum logic [1:0] {
		KIND_TICK    = 2'd0,
		KIND_OUTCOME = 2'd1,
		KIND_MANUAL  = 2'd2,
		KIND_RELOAD  = 2'd3
	} kind_t;

	// Heat state encoding shared by desired and applied state.
	typedef enum logic [1:0] {
		ST_UNKNOWN = 2'd0,
		ST_OFF     = 2'd1,
		ST_ON      = 2'd2
	} heat_st_t;

	// Configuration register indexes.
	typedef enum logic [IDX_W-1:0] {
		CFG_ENABLE     = 3'd0,
		CFG_WEEKDAY_N  = 3'd1,
		CFG_WEEKEND_N  = 3'd2,
		CFG_WEEKDAY_LO = 3'd3,
		CFG_WEEKDAY_HI = 3'd4,
		CFG_WEEKEND_LO = 3'd5,
		CFG_WEEKEND_HI = 3'd6
	} cfg_idx_t;

	typedef logic [MIN_W-1:0] minute_t;

	typedef struct packed {
		kind_t       kind;
		logic [4:0]  hour;
		logic [5:0]  minute;
		logic [2:0]  day_of_week;
		logic        time_valid;
		logic        outcome_ok;
		logic        manual_on;
	} in_item_t;

	typedef struct packed {
		logic      issue_command;
		logic      command_on;
		heat_st_t  desired_state;
		heat_st_t  applied_state;
		logic      backing_off;
	} out_item_t;

	typedef struct packed {
		logic              enable;
		logic [CNT_W-1:0]  weekday_count;
		logic [CNT_W-1:0]  weekend_count;
		logic [SLOT_W-1:0] weekday_lo;
		logic [SLOT_W-1:0] weekday_hi;
		logic [SLOT_W-1:0] weekend_lo;
		logic [SLOT_W-1:0] weekend_hi;
	} cfg_regs_t;

endpackage

`default_nettype wire

// File: rtl/wwhs_if.sv
// Valid/ready channel interfaces: input items, result items and register writes.
// Depends on wwhs_pkg for the payload types.
`default_nettype none

interface wwhs_in_if import wwhs_pkg::*; ();
	logic     valid;
	logic     ready;
	in_item_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

interface wwhs_out_if import wwhs_pkg::*; ();
	logic      valid;
	logic      ready;
	out_item_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

interface wwhs_cfg_if import wwhs_pkg::*; ();
	logic              valid;
	logic              ready;
	logic [IDX_W-1:0]  index;
	logic [SLOT_W-1:0] data;

	modport source (output valid, output index, output data, input ready);
	modport sink (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

// File: rtl/wwhs_match.sv
// Window match unit: tests the minute of day against the weekday or weekend windows.
// Depends on wwhs_pkg for the register struct and minute type.
`default_nettype none

module wwhs_match import wwhs_pkg::*; #(
	parameter int WINDOWS = 4
) (
	input  wire logic [4:0] hour,
	input  wire logic [5:0] minute,
	input  wire logic [2:0] day_of_week,
	input  wire cfg_regs_t  regs,
	output logic            want_on
);

	// A window with equal ends never matches; an end below the start wraps midnight.
	function automatic logic window_hit(input minute_t now, input minute_t start,
			input minute_t stop);
		logic hit;
		if (start == stop) begin
			hit = 1'b0;
		end else if (start < stop) begin
			hit = (now >= start) && (now < stop);
		end else begin
			hit = (now >= start) || (now < stop);
		end
		return hit;
	endfunction

	minute_t           now;
	logic              weekday;
	logic [CNT_W-1:0]  count;
	logic [SLOT_W-1:0] word_lo;
	logic [SLOT_W-1:0] word_hi;
	logic [WINDOWS-1:0] hits;

	// Minute of day: hour * 60 as (hour << 6) - (hour << 2), plus minute.
	assign now = ({1'b0, hour, 5'd0} << 1) - {4'd0, hour, 2'd0} + {5'd0, minute};

	// Days one to five use the weekday set; all other codes use the weekend set.
	assign weekday = (day_of_week >= 3'd1) && (day_of_week <= 3'd5);
	assign count   = weekday ? regs.weekday_count : regs.weekend_count;
	assign word_lo = weekday ? regs.weekday_lo : regs.weekend_lo;
	assign word_hi = weekday ? regs.weekday_hi : regs.weekend_hi;

	// One comparator pair per window, all in parallel.
	for (genvar i = 0; i < WINDOWS; i++) begin : g_win
		localparam int BASE = (i % 2) * 2 * MIN_W;
		logic [SLOT_W-1:0] word;
		assign word    = (i < 2) ? word_lo : word_hi;
		assign hits[i] = (CNT_W'(i) < count) &&
			window_hit(now, word[BASE +: MIN_W], word[BASE + MIN_W +: MIN_W]);
	end

	assign want_on = |hits;

endmodule

`default_nettype wire

// File: rtl/wwhs_ctrl.sv
// Scheduler control: sync, command, outcome and backoff state with its update logic.
// Depends on wwhs_pkg for item, result and state types.
`default_nettype none

module wwhs_ctrl import wwhs_pkg::*; #(
	parameter int FAIL_LIMIT    = 3,
	parameter int BACKOFF_TICKS = 10
) (
	input  wire logic     clk,
	input  wire logic     arst_n,
	input  wire logic     step,
	input  wire in_item_t item,
	input  wire logic     want_on,
	input  wire logic     enable,
	output out_item_t     result
);

	localparam int STREAK_W = (FAIL_LIMIT > 1) ? $clog2(FAIL_LIMIT + 1) : 1;
	localparam int SKIP_W   = (BACKOFF_TICKS > 1) ? $clog2(BACKOFF_TICKS + 1) : 1;

	heat_st_t            last_wanted_q, last_wanted_d;
	heat_st_t            applied_q, applied_d;
	logic                synced_q, synced_d;
	logic [STREAK_W-1:0] streak_q, streak_d;
	logic [SKIP_W-1:0]   skip_q, skip_d;
	logic                pending_q, pending_d;
	logic                pend_val_q, pend_val_d;

	logic              go;
	logic              issue;
	logic              cmd;
	heat_st_t          wanted;
	heat_st_t          desired;
	logic [STREAK_W:0] streak_inc;

	assign wanted     = want_on ? ST_ON : ST_OFF;
	assign desired    = (enable && item.time_valid) ? wanted : ST_UNKNOWN;
	assign streak_inc = {1'b0, streak_q} + {{STREAK_W{1'b0}}, 1'b1};

	// Next state for the item that moves to the result register this cycle.
	always_comb begin
		last_wanted_d = last_wanted_q;
		applied_d     = applied_q;
		synced_d      = synced_q;
		streak_d      = streak_q;
		skip_d        = skip_q;
		pending_d     = pending_q;
		pend_val_d    = pend_val_q;
		go            = 1'b0;
		issue         = 1'b0;
		cmd           = 1'b0;
		case (item.kind)
			KIND_TICK: begin
				if (!pending_q) begin
					go = 1'b1;
					if (item.time_valid && !synced_q) begin
						last_wanted_d = ST_UNKNOWN;
						applied_d     = ST_UNKNOWN;
						synced_d      = 1'b1;
					end else if (!item.time_valid) begin
						last_wanted_d = ST_UNKNOWN;
						go            = 1'b0;
					end
					if (go && !enable) begin
						last_wanted_d = ST_UNKNOWN;
						go            = 1'b0;
					end
					if (go && (skip_q != '0)) begin
						skip_d = skip_q - SKIP_W'(1);
						go     = 1'b0;
					end
					if (go && ((last_wanted_d == ST_UNKNOWN) || (last_wanted_d != wanted))) begin
						issue      = 1'b1;
						cmd        = want_on;
						pending_d  = 1'b1;
						pend_val_d = want_on;
					end
				end
			end
			KIND_OUTCOME: begin
				if (pending_q) begin
					pending_d = 1'b0;
					if (item.outcome_ok) begin
						applied_d     = pend_val_q ? ST_ON : ST_OFF;
						last_wanted_d = pend_val_q ? ST_ON : ST_OFF;
						streak_d      = '0;
					end else if (streak_inc >= (STREAK_W + 1)'(FAIL_LIMIT)) begin
						skip_d   = SKIP_W'(BACKOFF_TICKS);
						streak_d = '0;
					end else begin
						streak_d = streak_inc[STREAK_W-1:0];
					end
				end
			end
			KIND_MANUAL: begin
				applied_d = item.manual_on ? ST_ON : ST_OFF;
			end
			default: begin
				last_wanted_d = ST_UNKNOWN;
				streak_d      = '0;
				skip_d        = '0;
			end
		endcase
	end

	// Result for the item, reflecting the state after it.
	always_comb begin
		result.issue_command = issue;
		result.command_on    = cmd;
		result.desired_state = desired;
		result.applied_state = applied_d;
		result.backing_off   = (skip_d != '0);
	end

	// State registers advance only when an item completes.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			last_wanted_q <= ST_UNKNOWN;
			applied_q     <= ST_UNKNOWN;
			synced_q      <= 1'b0;
			streak_q      <= '0;
			skip_q        <= '0;
			pending_q     <= 1'b0;
			pend_val_q    <= 1'b0;
		end else if (step) begin
			last_wanted_q <= last_wanted_d;
			applied_q     <= applied_d;
			synced_q      <= synced_d;
			streak_q      <= streak_d;
			skip_q        <= skip_d;
			pending_q     <= pending_d;
			pend_val_q    <= pend_val_d;
		end
	end

endmodule

`default_nettype wire

// File: rtl/weekly_window_heat_scheduler.sv
// Top level of the weekly window heat scheduler: channel registers, config registers.
// Depends on wwhs_pkg, the wwhs_*_if interfaces, wwhs_match and wwhs_ctrl.
//
//   channel   dir   payload                                          beat
//   items     in    kind, hour, minute, day_of_week, flags           one item
//   results   out   issue_command, command_on, desired/applied, ...  one result
//   cfg       in    index, data (44 bits)                            one register write
//
// One result per item, one item per cycle sustained while results are taken; the path is the input
// register, then window compares and state update into the result register.
// Register writes are always ready and take effect on the next cycle.
// Reset clears all scheduler state, the configuration registers and both valid flags.
// A stalled result holds; the input register still fills, then items back-pressure.
`default_nettype none

module weekly_window_heat_scheduler import wwhs_pkg::*; #(
	parameter int WINDOWS       = 4,
	parameter int FAIL_LIMIT    = 3,
	parameter int BACKOFF_TICKS = 10
) (
	input  wire logic  clk,
	input  wire logic  arst_n,
	wwhs_in_if.sink    items,
	wwhs_out_if.source results,
	wwhs_cfg_if.sink   cfg
);

	cfg_regs_t  cfg_q;
	in_item_t   item_s1;
	logic       valid_s1;
	out_item_t  res_q;
	logic       res_valid_q;
	logic       advance;
	logic       want_on;
	out_item_t  res_d;

	// Pipeline control: the input stage moves on when the result slot is free.
	assign advance     = valid_s1 && (!res_valid_q || results.ready);
	assign items.ready = !valid_s1 || advance;
	assign cfg.ready   = 1'b1;

	// Configuration register writes.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '0;
		end else if (cfg.valid) begin
			unique case (cfg.index)
				CFG_ENABLE:     cfg_q.enable        <= cfg.data[0];
				CFG_WEEKDAY_N:  cfg_q.weekday_count <= cfg.data[CNT_W-1:0];
				CFG_WEEKEND_N:  cfg_q.weekend_count <= cfg.data[CNT_W-1:0];
				CFG_WEEKDAY_LO: cfg_q.weekday_lo    <= cfg.data;
				CFG_WEEKDAY_HI: cfg_q.weekday_hi    <= cfg.data;
				CFG_WEEKEND_LO: cfg_q.weekend_lo    <= cfg.data;
				CFG_WEEKEND_HI: cfg_q.weekend_hi    <= cfg.data;
				default: ;
			endcase
		end
	end

	// Input register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (items.ready) begin
			valid_s1 <= items.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (items.valid && items.ready) begin
			item_s1 <= items.data;
		end
	end

	wwhs_match #(
		.WINDOWS (WINDOWS)
	) u_match (
		.hour        (item_s1.hour),
		.minute      (item_s1.minute),
		.day_of_week (item_s1.day_of_week),
		.regs        (cfg_q),
		.want_on     (want_on)
	);

	wwhs_ctrl #(
		.FAIL_LIMIT    (FAIL_LIMIT),
		.BACKOFF_TICKS (BACKOFF_TICKS)
	) u_ctrl (
		.clk     (clk),
		.arst_n  (arst_n),
		.step    (advance),
		.item    (item_s1),
		.want_on (want_on),
		.enable  (cfg_q.enable),
		.result  (res_d)
	);

	// Result register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (advance) begin
			res_valid_q <= 1'b1;
		end else if (results.ready) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			res_q <= res_d;
		end
	end

	assign results.valid = res_valid_q;
	assign results.data  = res_q;

endmodule

`default_nettype wire

// File: rtl/wwhs_checker.sv
// Port-level checks on the scheduler's result channel, bound to the top level.
// Depends on wwhs_pkg for the result type and state codes.
`default_nettype none

module wwhs_checker import wwhs_pkg::*; (
	input wire logic      clk,
	input wire logic      arst_n,
	input wire logic      out_valid,
	input wire logic      out_ready,
	input wire out_item_t out_data
);

	// A stalled result beat stays and holds its payload.
	a_stall_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_data))
		else $error("result beat changed while stalled");

	// The command value is zero unless a command is issued.
	a_cmd_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_data.issue_command |-> !out_data.command_on)
		else $error("command_on set without issue_command");

	// An issued command always follows the desired state of the same tick.
	a_cmd_match: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_data.issue_command |->
			(out_data.command_on && out_data.desired_state == ST_ON) ||
			(!out_data.command_on && out_data.desired_state == ST_OFF))
		else $error("issued command disagrees with desired state");

	// The applied state never takes the unused code.
	a_applied_code: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> out_data.applied_state != 2'd3)
		else $error("applied state holds an unused code");

endmodule

bind weekly_window_heat_scheduler wwhs_checker u_wwhs_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.out_valid (results.valid),
	.out_ready (results.ready),
	.out_data  (results.data)
);

`default_nettype wire
